@@ hdl/bpc_pkg.sv @@
// Shared types and constants for the pressure compensation block.
`default_nettype none
package bpc_pkg;
  localparam int unsigned DataW   = 32;
  localparam int unsigned RawW    = 19;
  localparam int unsigned CfgIdxW = 3;

  typedef enum logic [2:0] {
    REG_AC1_AC2 = 3'd0,
    REG_AC3_AC4 = 3'd1,
    REG_AC5_AC6 = 3'd2,
    REG_B1_B2   = 3'd3,
    REG_MC_MD   = 3'd4,
    REG_OSS     = 3'd5
  } cfg_reg_e;

  localparam logic [DataW-1:0] B6Off   = 32'd4000;
  localparam logic [DataW-1:0] B7Scale = 32'd50000;
  localparam logic [DataW-1:0] B4Bias  = 32'd32768;
  localparam logic [DataW-1:0] MgCoef  = 32'd3038;
  localparam logic [DataW-1:0] MhCoef  = 32'hFFFFE343;
  localparam logic [DataW-1:0] MiCoef  = 32'd3791;
  localparam logic [DataW-1:0] SignBit = 32'h80000000;

  typedef struct packed {
    logic             start;
    logic [DataW-1:0] dividend;
    logic [DataW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DataW-1:0] quotient;
  } div_rsp_t;

  function automatic logic [DataW-1:0] sx16(input logic [15:0] h);
    return {{16{h[15]}}, h};
  endfunction
endpackage
`default_nettype wire

@@ hdl/bpc_div.sv @@
// Bit-serial unsigned 32-bit restoring divider, one quotient bit per cycle.
`default_nettype none
module bpc_div
  import bpc_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire div_req_t req_i,
  output div_rsp_t      rsp_o
);
  localparam int unsigned CntW = $clog2(DataW + 1);

  logic [DataW-1:0] rem_q, rem_d, quo_q, quo_d, dvs_q, dvs_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             busy_q, busy_d, done_q, done_d;
  logic [DataW:0]   trial;
  logic [DataW:0]   shifted;

  always_comb begin
    shifted = {rem_q, quo_q[DataW-1]};
    trial   = shifted - {1'b0, dvs_q};
    rem_d   = rem_q;
    quo_d   = quo_q;
    dvs_d   = dvs_q;
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    done_d  = 1'b0;
    if (req_i.start) begin
      rem_d  = '0;
      quo_d  = req_i.dividend;
      dvs_d  = req_i.divisor;
      cnt_d  = CntW'(DataW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!trial[DataW]) begin
        rem_d = trial[DataW-1:0];
        quo_d = {quo_q[DataW-2:0], 1'b1};
      end else begin
        rem_d = shifted[DataW-1:0];
        quo_d = {quo_q[DataW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;
endmodule
`default_nettype wire

@@ hdl/barometric_pressure_compensation_unit.sv @@
// Top level: sequencer with a shared multiplier and a serial divider.
// Usage:
//   Input stream: tuser = action (0 temperature, 1 pressure), tdata[18:0] =
//   raw reading. Output stream: tuser = kind, tdata[31:0] = value,
//   tdata[32] = div_error. One result per transfer in.
//   Configuration: write cfg_we_i with cfg_idx_i / cfg_data_i while idle.
//   Indexes beyond the list are ignored.
//   One item at a time: s_axis_tready is high only when the sequencer idles.
//   A temperature item passes the steps multiply, check, divide and finish, a
//   pressure item a longer chain of multiplies around one division; a zero
//   divisor goes straight to the output step. The next transfer in is taken
//   once the sequencer is back in idle. The serial divider and the single
//   registered 32x32 multiplier used once per step set the time per item.
//   The result sits in an output register; a stalled receiver holds it and
//   the sequencer waits in its final step until the register frees up,
//   while the next item may already be accepted once it is moved out.
//   Reset clears calibration registers, the stored b5 and all control state.
`default_nettype none
module barometric_pressure_compensation_unit
  import bpc_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               s_axis_tvalid,
  output logic                    s_axis_tready,
  input  wire logic [23:0]        s_axis_tdata,  // [18:0] raw_reading
  input  wire logic               s_axis_tuser,  // [0] action
  output logic                    m_axis_tvalid,
  input  wire logic               m_axis_tready,
  output logic [39:0]             m_axis_tdata,  // [31:0] value, [32] div_error
  output logic                    m_axis_tuser,  // [0] kind
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [DataW-1:0]   cfg_data_i
);
  typedef enum logic [19:0] {
    S_IDLE  = 20'h00001,
    S_T_MUL = 20'h00002,
    S_T_CHK = 20'h00004,
    S_T_DIV = 20'h00008,
    S_T_FIN = 20'h00010,
    S_P_SQ  = 20'h00020,
    S_P_X1  = 20'h00040,
    S_P_B3  = 20'h00080,
    S_P_X1B = 20'h00100,
    S_P_X3  = 20'h00200,
    S_P_X3S = 20'h00400,
    S_P_B4M = 20'h00800,
    S_P_B7M = 20'h01000,
    S_P_DVS = 20'h02000,
    S_P_DIV = 20'h04000,
    S_P_PM  = 20'h08000,
    S_P_X1M = 20'h10000,
    S_P_X2M = 20'h20000,
    S_P_FIN = 20'h40000,
    S_OUT   = 20'h80000
  } state_e;

  state_e state_q, state_d;
  logic [DataW-1:0] r0_q, r1_q, r2_q, r3_q, r4_q;
  logic [1:0]       oss_q;
  logic [DataW-1:0] b5_q, b5_d;
  logic [RawW-1:0]  raw_q, raw_d;
  logic [DataW-1:0] prod_q, mul_a, mul_b;
  logic [DataW-1:0] x1_q, x1_d, sq_q, sq_d, x3_q, x3_d, b3_q, b3_d, b4_q, b4_d;
  logic [DataW-1:0] p_q, p_d, res_q, res_d;
  logic             err_q, err_d, kind_q, kind_d, dflag_q, dflag_d, dneg_q, dneg_d;
  logic             ov_q, ov_d;
  logic [39:0]      odata_q, odata_d;
  logic             okind_q, okind_d;
  div_req_t         dreq;
  div_rsp_t         drsp;

  logic [DataW-1:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md, b6;
  logic [DataW-1:0] asr11, asr12, asr13, asr15, asr16, tx1, td, tnum, qs, tb5;
  logic [DataW-1:0] x3a, b3a, pp, px2, pfin;
  logic             accept;

  assign ac1 = sx16(r0_q[31:16]);
  assign ac2 = sx16(r0_q[15:0]);
  assign ac3 = sx16(r1_q[31:16]);
  assign ac4 = {16'd0, r1_q[15:0]};
  assign ac5 = {16'd0, r2_q[31:16]};
  assign ac6 = {16'd0, r2_q[15:0]};
  assign b1  = sx16(r3_q[31:16]);
  assign b2  = sx16(r3_q[15:0]);
  assign mc  = sx16(r4_q[31:16]);
  assign md  = sx16(r4_q[15:0]);
  assign b6  = b5_q - B6Off;

  assign asr11 = DataW'($signed(prod_q) >>> 11);
  assign asr12 = DataW'($signed(prod_q) >>> 12);
  assign asr13 = DataW'($signed(prod_q) >>> 13);
  assign asr15 = DataW'($signed(prod_q) >>> 15);
  assign asr16 = DataW'($signed(prod_q) >>> 16);

  assign tx1  = asr15;
  assign td   = tx1 + md;
  assign tnum = mc << 11;
  assign qs   = dneg_q ? (~drsp.quotient + 1'b1) : drsp.quotient;
  assign tb5  = x1_q + qs;

  assign x3a  = x1_q + asr11;
  assign b3a  = DataW'($signed(((ac1 << 2) + x3a) << oss_q) + 2) >>> 2;
  assign pp   = DataW'($signed(p_q) >>> 8);
  assign px2  = asr16;
  assign pfin = p_q + DataW'($signed(x1_q + px2 + MiCoef) >>> 4);

  assign accept = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == S_IDLE);

  always_comb begin
    mul_a = p_q;
    mul_b = MhCoef;
    case (state_q)
      S_T_MUL: begin mul_a = {13'd0, raw_q} - ac6; mul_b = ac5; end
      S_P_SQ:  begin mul_a = b6; mul_b = b6; end
      S_P_X1:  begin mul_a = asr12; mul_b = b2; end
      S_P_B3:  begin mul_a = ac2; mul_b = b6; end
      S_P_X1B: begin mul_a = ac3; mul_b = b6; end
      S_P_X3:  begin mul_a = b1; mul_b = sq_q; end
      S_P_B4M: begin mul_a = ac4; mul_b = x3_q + B4Bias; end
      S_P_B7M: begin mul_a = {13'd0, raw_q} - b3_q; mul_b = B7Scale >> oss_q; end
      S_P_PM:  begin mul_a = pp; mul_b = pp; end
      S_P_X1M: begin mul_a = prod_q; mul_b = MgCoef; end
      default: begin mul_a = p_q; mul_b = MhCoef; end
    endcase
  end

  always_comb begin
    state_d = state_q;
    b5_d = b5_q; raw_d = raw_q; x1_d = x1_q; sq_d = sq_q; x3_d = x3_q;
    b3_d = b3_q; b4_d = b4_q; p_d = p_q; res_d = res_q; err_d = err_q;
    kind_d = kind_q; dflag_d = dflag_q; dneg_d = dneg_q;
    ov_d = ov_q; odata_d = odata_q; okind_d = okind_q;
    dreq = '0;
    if (ov_q && m_axis_tready) ov_d = 1'b0;
    unique case (state_q)
      S_IDLE: if (accept) begin
        raw_d   = s_axis_tdata[RawW-1:0];
        kind_d  = s_axis_tuser;
        state_d = s_axis_tuser ? S_P_SQ : S_T_MUL;
      end
      S_T_MUL: state_d = S_T_CHK;
      S_T_CHK: begin
        x1_d = tx1;
        if (td == '0) begin
          res_d = '0; err_d = 1'b1; state_d = S_OUT;
        end else begin
          dneg_d        = tnum[31] ^ td[31];
          dreq.start    = 1'b1;
          dreq.dividend = tnum[31] ? (~tnum + 1'b1) : tnum;
          dreq.divisor  = td[31] ? (~td + 1'b1) : td;
          state_d       = S_T_DIV;
        end
      end
      S_T_DIV: if (drsp.done) state_d = S_T_FIN;
      S_T_FIN: begin
        b5_d  = tb5;
        res_d = DataW'($signed(tb5 + 32'd8) >>> 4);
        err_d = 1'b0;
        state_d = S_OUT;
      end
      S_P_SQ:  state_d = S_P_X1;
      S_P_X1:  begin sq_d = asr12; state_d = S_P_B3; end
      S_P_B3:  begin x1_d = asr11; state_d = S_P_X1B; end
      S_P_X1B: begin b3_d = b3a; state_d = S_P_X3; end
      S_P_X3:  begin x1_d = asr13; state_d = S_P_X3S; end
      S_P_X3S: begin
        x3_d = DataW'($signed(x1_q + asr16 + 32'd2) >>> 2);
        state_d = S_P_B4M;
      end
      S_P_B4M: state_d = S_P_B7M;
      S_P_B7M: begin
        b4_d = prod_q >> 15;
        if ((prod_q >> 15) == '0) begin
          res_d = '0; err_d = 1'b1; state_d = S_OUT;
        end else begin
          state_d = S_P_DVS;
        end
      end
      S_P_DVS: begin
        dflag_d       = (prod_q >= SignBit);
        dreq.start    = 1'b1;
        dreq.dividend = (prod_q >= SignBit) ? prod_q : (prod_q << 1);
        dreq.divisor  = b4_q;
        state_d       = S_P_DIV;
      end
      S_P_DIV: if (drsp.done) begin
        p_d = dflag_q ? (drsp.quotient << 1) : drsp.quotient;
        state_d = S_P_PM;
      end
      S_P_PM:  state_d = S_P_X1M;
      S_P_X1M: state_d = S_P_X2M;
      S_P_X2M: begin x1_d = asr16; state_d = S_P_FIN; end
      S_P_FIN: begin res_d = pfin; err_d = 1'b0; state_d = S_OUT; end
      S_OUT: if (!ov_q || m_axis_tready) begin
        ov_d    = 1'b1;
        odata_d = {7'd0, err_q, res_q};
        okind_d = kind_q;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  bpc_div u_div (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (dreq),
    .rsp_o (drsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ov_q    <= 1'b0;
      b5_q    <= '0;
      r0_q <= '0; r1_q <= '0; r2_q <= '0; r3_q <= '0; r4_q <= '0;
      oss_q   <= '0;
    end else begin
      state_q <= state_d;
      ov_q    <= ov_d;
      b5_q    <= b5_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_AC1_AC2: r0_q <= cfg_data_i;
          REG_AC3_AC4: r1_q <= cfg_data_i;
          REG_AC5_AC6: r2_q <= cfg_data_i;
          REG_B1_B2:   r3_q <= cfg_data_i;
          REG_MC_MD:   r4_q <= cfg_data_i;
          REG_OSS:     oss_q <= cfg_data_i[1:0];
          default:     ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q  <= mul_a * mul_b;
    raw_q   <= raw_d;
    x1_q    <= x1_d;
    sq_q    <= sq_d;
    x3_q    <= x3_d;
    b3_q    <= b3_d;
    b4_q    <= b4_d;
    p_q     <= p_d;
    res_q   <= res_d;
    err_q   <= err_d;
    kind_q  <= kind_d;
    dflag_q <= dflag_d;
    dneg_q  <= dneg_d;
    odata_q <= odata_d;
    okind_q <= okind_d;
  end

  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = odata_q;
  assign m_axis_tuser  = okind_q;
endmodule
`default_nettype wire

@@ tb/sv/tb_barometric_pressure_compensation_unit.sv @@
// Testbench for the barometric pressure compensation unit: predicted results vs. output stream.
`timescale 1ns / 1ps
module tb_barometric_pressure_compensation_unit
  import bpc_pkg::*;
();

  typedef struct packed {
    logic        act;
    logic [18:0] raw;
  } conv_t;

  typedef struct packed {
    logic        kind;
    logic [31:0] value;
    logic        err;
  } comp_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [23:0] s_axis_tdata = '0;
  logic s_axis_tuser = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;
  logic m_axis_tuser;
  logic cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = '0;
  logic [DataW-1:0] cfg_data_i = '0;

  always #5 clk_i = ~clk_i;

  barometric_pressure_compensation_unit u_dut (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  logic [31:0] cal [6];
  logic [31:0] b5_kept;
  conv_t pending_q[$];
  comp_t expected_q[$];
  int n_mismatch = 0;
  int n_results = 0;
  int n_temp = 0;
  int n_press = 0;
  int n_diverr = 0;
  bit no_idle = 1'b0;
  bit send_hold = 1'b0;

  function automatic logic [31:0] asr(input logic [31:0] v, input int s);
    return 32'($signed(v) >>> s);
  endfunction

  function automatic logic [31:0] sh(input logic [15:0] h);
    return {{16{h[15]}}, h};
  endfunction

  function automatic comp_t compensate(input conv_t c);
    comp_t r;
    logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
    logic [31:0] x1, x2, x3, d, b3, b4, b6, b7, sq, p, u;
    logic signed [63:0] q;
    int oss;
    ac1 = sh(cal[REG_AC1_AC2][31:16]); ac2 = sh(cal[REG_AC1_AC2][15:0]);
    ac3 = sh(cal[REG_AC3_AC4][31:16]); ac4 = {16'd0, cal[REG_AC3_AC4][15:0]};
    ac5 = {16'd0, cal[REG_AC5_AC6][31:16]}; ac6 = {16'd0, cal[REG_AC5_AC6][15:0]};
    b1 = sh(cal[REG_B1_B2][31:16]); b2 = sh(cal[REG_B1_B2][15:0]);
    mc = sh(cal[REG_MC_MD][31:16]); md = sh(cal[REG_MC_MD][15:0]);
    oss = int'(cal[REG_OSS][1:0]);
    u = {13'd0, c.raw};
    r.kind = c.act;
    r.value = '0;
    r.err = 1'b0;
    if (!c.act) begin
      x1 = asr((u - ac6) * ac5, 15);
      d = x1 + md;
      if (d == 0) begin
        r.err = 1'b1;
      end else begin
        q = 64'($signed(mc << 11)) / 64'($signed(d));
        b5_kept = x1 + q[31:0];
        r.value = asr(b5_kept + 32'd8, 4);
      end
    end else begin
      b6 = b5_kept - 32'd4000;
      sq = asr(b6 * b6, 12);
      x3 = asr(sq * b2, 11) + asr(ac2 * b6, 11);
      b3 = asr(((ac1 * 4 + x3) << oss) + 32'd2, 2);
      x3 = asr(asr(ac3 * b6, 13) + asr(b1 * sq, 16) + 32'd2, 2);
      b4 = (ac4 * (x3 + 32'd32768)) >> 15;
      if (b4 == 0) begin
        r.err = 1'b1;
      end else begin
        b7 = (u - b3) * (32'd50000 >> oss);
        p = b7[31] ? (b7 / b4) << 1 : (b7 << 1) / b4;
        x1 = asr(p, 8);
        x1 = asr(x1 * x1 * 32'd3038, 16);
        x2 = asr(p * 32'hFFFFE343, 16);
        r.value = p + asr(x1 + x2 + 32'd3791, 4);
      end
    end
    return r;
  endfunction

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] exp);
    $display("ERROR result %0d %s: got %h expected %h", n_results, what, got, exp);
    n_mismatch++;
  endtask

  // driver
  always @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      expected_q.push_back(compensate(conv_t'({s_axis_tuser, s_axis_tdata[18:0]})));
      if (s_axis_tuser) n_press++; else n_temp++;
    end
    if (!s_axis_tvalid || s_axis_tready) begin
      if (rst_ni && !send_hold && pending_q.size() > 0 &&
          (no_idle || $urandom_range(99) >= 31)) begin
        conv_t c;
        c = pending_q.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= c.act;
        s_axis_tdata <= {5'd0, c.raw};
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) begin
      comp_t e;
      n_results++;
      if (expected_q.size() == 0) begin
        report("unexpected", 64'({m_axis_tuser, m_axis_tdata}), '0);
      end else begin
        e = expected_q.pop_front();
        if (m_axis_tuser !== e.kind) report("kind", 64'(m_axis_tuser), 64'(e.kind));
        if (m_axis_tdata[31:0] !== e.value)
          report("value", 64'(m_axis_tdata[31:0]), 64'(e.value));
        if (m_axis_tdata[32] !== e.err)
          report("div_error", 64'(m_axis_tdata[32]), 64'(e.err));
        if (e.err) n_diverr++;
      end
    end
    m_axis_tready <= no_idle || $urandom_range(99) >= 31;
  end

  task automatic write_cal(input cfg_reg_e idx, input logic [31:0] v);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_OSS) cal[idx] = {30'd0, v[1:0]};
    else cal[idx] = v;
  endtask

  task automatic drain;
    while (pending_q.size() > 0 || s_axis_tvalid || expected_q.size() > 0)
      @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  // typical datasheet calibration
  task automatic load_typical(input logic [1:0] oss);
    write_cal(REG_AC1_AC2, {16'd408, 16'hFFB8});
    write_cal(REG_AC3_AC4, {16'hC3A4, 16'd32741});
    write_cal(REG_AC5_AC6, {16'd32757, 16'd23153});
    write_cal(REG_B1_B2, {16'd6190, 16'd4});
    write_cal(REG_MC_MD, {16'hD4BD, 16'd2868});
    write_cal(REG_OSS, {30'd0, oss});
  endtask

  task automatic add(input logic act, input logic [18:0] raw);
    conv_t c;
    c.act = act;
    c.raw = raw;
    pending_q.push_back(c);
  endtask

  initial begin
    for (int i = 0; i < 6; i++) cal[i] = '0;
    b5_kept = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    // pressure before any temperature, all-zero calibration (zero divisors)
    add(1'b1, 19'd0);
    add(1'b0, 19'd0);
    add(1'b1, 19'h7FFFF);
    drain();
    load_typical(2'd0);
    add(1'b0, 19'd27898);
    add(1'b1, 19'd23843);
    add(1'b0, 19'd0);
    add(1'b0, 19'h7FFFF);
    add(1'b0, 19'hFFFF);
    add(1'b1, 19'd0);
    add(1'b1, 19'h7FFFF);
    add(1'b0, 19'd27898);
    add(1'b1, 19'h40000);
    drain();
    write_cal(REG_OSS, 32'hFFFFFFFF);
    write_cal(REG_MC_MD, 32'h80007FFF);
    add(1'b0, 19'd30000);
    add(1'b1, 19'h55555);
    add(1'b1, 19'h2AAAA);
    drain();
    // temperature divisor zero: x1 is zero with ac5 = 0, and md = 0
    write_cal(REG_AC5_AC6, 32'h0000FFFF);
    write_cal(REG_MC_MD, 32'h7FFF0000);
    add(1'b0, 19'd1234);
    add(1'b1, 19'd5000);
    drain();
    write_cal(REG_AC3_AC4, 32'h7FFF0000);
    add(1'b1, 19'd5000);
    drain();
    for (int ph = 0; ph < 12; ph++) begin
      if (ph % 3 == 0) begin
        load_typical(2'(ph / 3));
      end else begin
        write_cal(REG_AC1_AC2, $urandom);
        write_cal(REG_AC3_AC4, $urandom);
        write_cal(REG_AC5_AC6, $urandom);
        write_cal(REG_B1_B2, $urandom);
        write_cal(REG_MC_MD, $urandom);
        write_cal(REG_OSS, $urandom);
      end
      no_idle = (ph == 5);
      for (int i = 0; i < 150; i++) begin
        if ($urandom_range(3) == 0) add(1'b0, 19'($urandom));
        else if ($urandom_range(4) == 0) add(1'b1, 19'($urandom));
        else if ($urandom_range(1) == 0) add(1'b0, 19'($urandom_range(33000, 22000)));
        else add(1'b1, 19'($urandom_range(90000, 15000) << cal[REG_OSS][1:0]));
        if (i == 70 && ph == 2) begin
          while (pending_q.size() > 0 || s_axis_tvalid) @(posedge clk_i);
          send_hold = 1'b1;
          while (expected_q.size() > 0) @(posedge clk_i);
          send_hold = 1'b0;
        end
      end
      drain();
    end
    $display("Covered %0d temperature and %0d pressure conversions, %0d with zero divisor.",
             n_temp, n_press, n_diverr);
    $display("Calibration sets: zero, typical at every oversampling, random and extremes.");
    if (n_mismatch == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

  initial begin
    #20ms;
    $display("Mismatches found");
    $finish;
  end
endmodule
